// ===== rtl/slpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slpt_pkg;

    localparam int KEY_W  = 64;
    localparam int TS_W   = 63;
    localparam int TICK_W = 64;
    localparam int CNT_W  = 32;
    localparam int RS_W   = 4;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic signed [TICK_W-1:0] TICK_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [TICK_W-1:0] TICK_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [CNT_W-1:0]         CNT_SAT  = 32'hFFFF_FFFF;

    // one table slot as stored in the slot memory
    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [TS_W-1:0]          start;
        logic signed [TICK_W-1:0] sum;
        logic [CNT_W-1:0]         count;
        logic signed [TICK_W-1:0] min;
        logic signed [TICK_W-1:0] max;
    } t_entry;

    typedef struct packed {
        logic [1:0]               status;
        logic [RS_W-1:0]          slot_index;
        logic                     slot_in_use;
        logic [KEY_W-1:0]         entry_key;
        logic signed [TICK_W-1:0] total_ticks;
        logic [CNT_W-1:0]         call_total;
        logic signed [TICK_W-1:0] min_ticks;
        logic signed [TICK_W-1:0] max_ticks;
    } t_result;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [TICK_W-1:0]   a;
        logic [TICK_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [TICK_W-1:0] res;
        logic              less;
    } t_alu_res;

endpackage
`default_nettype wire

// ===== rtl/slpt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface slpt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] section_key;
    logic [62:0] timestamp;
    logic [3:0]  read_slot;

    modport source (output valid, output opcode, output section_key, output timestamp,
                    output read_slot, input ready);
    modport sink   (input valid, input opcode, input section_key, input timestamp,
                    input read_slot, output ready);
endinterface

interface slpt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic               slot_in_use;
    logic [63:0]        entry_key;
    logic signed [63:0] total_ticks;
    logic [31:0]        call_total;
    logic signed [63:0] min_ticks;
    logic signed [63:0] max_ticks;

    modport source (output valid, output status, output slot_index, output slot_in_use,
                    output entry_key, output total_ticks, output call_total,
                    output min_ticks, output max_ticks, input ready);
    modport sink   (input valid, input status, input slot_index, input slot_in_use,
                    input entry_key, input total_ticks, input call_total,
                    input min_ticks, input max_ticks, output ready);
endinterface
`default_nettype wire

// ===== rtl/slpt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slpt_alu
    import slpt_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [TICK_W:0] ext_a;
    logic [TICK_W:0] ext_b;
    logic [TICK_W:0] total;

    // sign-extended so bit 64 of a difference is the signed a < b flag
    assign ext_a = {i_req.a[TICK_W-1], i_req.a};
    assign ext_b = {i_req.b[TICK_W-1], i_req.b};

    always_comb begin
        if (i_req.op == ALU_SUB) begin
            total = ext_a + ~ext_b + {{TICK_W{1'b0}}, 1'b1};
        end else begin
            total = ext_a + ext_b;
        end
    end

    assign o_res.res  = total[TICK_W-1:0];
    assign o_res.less = total[TICK_W];

endmodule
`default_nettype wire

// ===== rtl/section_latency_profiler_table.sv =====
// Section latency profiler table.
// Input channel i_in carries an opcode (begin, end, read, clear), a section key, a
// timestamp and a read slot; output channel o_out returns exactly one result per input
// transfer: status, slot index and the slot's key, tick total, call count, min and max.
// Begin and end walk the slot memory one slot per cycle through its registered read
// port, matching the key and noting the lowest free slot. End then runs four steps on
// the shared 64-bit add/compare unit: delta, new total, delta < min, max < delta.
// Begin and end stop the walk at the matched slot; allocate, table full and an unknown
// key walk to the last slot. Read and clear skip the walk and go straight to the result.
// One item is in flight at a time; i_in.ready is high only when the sequencer is idle,
// so a new item is taken only once the last one has reached the output register.
// A finished result sits in the output register; if o_out.ready is low the next item
// may still be accepted, but its result waits until the previous one is transferred.
// Reset (synchronous, active low) empties the table via per-slot valid flip-flops and
// drops any pending result; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module section_latency_profiler_table
    import slpt_pkg::*;
#(
    parameter int SLOTS = 16
)(
    input  wire          i_clk,
    input  wire          i_rst_n,
    slpt_in_if.sink      i_in,
    slpt_out_if.source   o_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = ((IW > RS_W) ? IW : RS_W) + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIFF,
        S_SUM,
        S_CMIN,
        S_CMAX,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        K_BEGIN_HIT,
        K_ALLOC,
        K_FULL,
        K_END,
        K_MISS,
        K_READ,
        K_CLEAR
    } t_kind;

    t_state                   r_state;
    t_kind                    r_kind;
    logic                     r_is_end;
    logic [KEY_W-1:0]         r_key;
    logic [TS_W-1:0]          r_ts;
    logic [RS_W-1:0]          r_rs;
    logic                     r_rs_ok;
    logic [IW-1:0]            r_slot;
    logic [IW-1:0]            r_idx;
    logic                     r_issued_all;
    logic                     r_chk;
    logic [IW-1:0]            r_chk_idx;
    logic                     r_free_found;
    logic [IW-1:0]            r_free;
    logic signed [TICK_W-1:0] r_d;
    logic signed [TICK_W-1:0] r_sum;
    logic                     r_lt;
    logic                     r_gt;
    logic [SLOTS-1:0]         r_valid;
    logic                     r_ovalid;
    t_result                  r_out;
    t_entry                   r_rd;
    t_entry                   r_mem [SLOTS];

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] rs_ext;
    logic          rs_ok;
    logic          chk_valid;
    logic          hit;
    logic          free_now;
    logic          any_free;
    logic [IW-1:0] first_free;
    logic          scan_last;
    logic          re;
    logic [IW-1:0] ra;
    logic          we;
    t_entry        wd;
    t_result       res;
    t_alu_req      alu_req;
    t_alu_res      alu_res;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;
    assign rs_ext     = {{(CW - RS_W){1'b0}}, i_in.read_slot};
    assign rs_ok      = rs_ext < CW'(SLOTS);
    assign chk_valid  = r_valid[r_chk_idx];
    assign hit        = r_chk && chk_valid && (r_rd.key == r_key);
    assign free_now   = r_chk && !chk_valid;
    assign any_free   = r_free_found || free_now;
    assign first_free = r_free_found ? r_free : r_chk_idx;
    assign scan_last  = r_chk && (r_chk_idx == LAST_IDX);

    slpt_alu u_slpt_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = r_d;
        alu_req.b  = r_rd.min;
        case (r_state)
            S_DIFF: begin
                alu_req.a = {1'b0, r_ts};
                alu_req.b = {1'b0, r_rd.start};
            end
            S_SUM: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_rd.sum;
                alu_req.b  = r_d;
            end
            S_CMAX: begin
                alu_req.a = r_rd.max;
                alu_req.b = r_d;
            end
            default: begin
            end
        endcase
    end

    // memory read: the requested slot on a read, the walk index during a scan
    always_comb begin
        re = 1'b0;
        ra = r_idx;
        case (r_state)
            S_IDLE: begin
                re = in_acc && (i_in.opcode == OP_READ) && rs_ok;
                ra = rs_ext[IW-1:0];
            end
            S_SCAN: begin
                re = !hit && !scan_last && !r_issued_all;
            end
            default: begin
            end
        endcase
    end

    // updated slot contents and the result for the item being finished
    always_comb begin
        wd  = r_rd;
        res = '0;
        case (r_kind)
            K_BEGIN_HIT: begin
                wd.start = r_ts;
            end
            K_ALLOC: begin
                wd.key   = r_key;
                wd.start = r_ts;
                wd.sum   = '0;
                wd.count = '0;
                wd.min   = TICK_MAX;
                wd.max   = TICK_MIN;
            end
            K_END: begin
                wd.sum = r_sum;
                if (r_rd.count != CNT_SAT) begin
                    wd.count = r_rd.count + CNT_W'(1);
                end
                if (r_lt) begin
                    wd.min = r_d;
                end
                if (r_gt) begin
                    wd.max = r_d;
                end
            end
            default: begin
            end
        endcase

        case (r_kind)
            K_BEGIN_HIT, K_ALLOC, K_END: begin
                res.status      = ST_OK;
                res.slot_index  = RS_W'(r_slot);
                res.slot_in_use = 1'b1;
                res.entry_key   = wd.key;
                res.total_ticks = wd.sum;
                res.call_total  = wd.count;
                res.min_ticks   = wd.min;
                res.max_ticks   = wd.max;
            end
            K_FULL: begin
                res.status = ST_FULL;
            end
            K_MISS: begin
                res.status = ST_NOT_FOUND;
            end
            K_READ: begin
                res.status     = ST_OK;
                res.slot_index = r_rs;
                res.min_ticks  = TICK_MAX;
                res.max_ticks  = TICK_MIN;
                // a free slot reads as its cleared contents
                if (r_rs_ok && r_valid[r_slot]) begin
                    res.slot_in_use = 1'b1;
                    res.entry_key   = r_rd.key;
                    res.total_ticks = r_rd.sum;
                    res.call_total  = r_rd.count;
                    res.min_ticks   = r_rd.min;
                    res.max_ticks   = r_rd.max;
                end
            end
            default: begin
            end
        endcase
    end

    assign we = (r_state == S_FIN) && out_free &&
                ((r_kind == K_BEGIN_HIT) || (r_kind == K_ALLOC) || (r_kind == K_END));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_slot] <= wd;
        end
        if (re) begin
            r_rd <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kind       <= K_CLEAR;
            r_valid      <= '0;
            r_ovalid     <= 1'b0;
            r_chk        <= 1'b0;
            r_issued_all <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
        end else begin
            // in S_FIN the output register is reloaded below instead
            if (r_ovalid && o_out.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key        <= i_in.section_key;
                        r_ts         <= i_in.timestamp;
                        r_rs         <= i_in.read_slot;
                        r_rs_ok      <= rs_ok;
                        r_slot       <= rs_ext[IW-1:0];
                        r_is_end     <= (i_in.opcode == OP_END);
                        r_idx        <= '0;
                        r_issued_all <= 1'b0;
                        r_chk        <= 1'b0;
                        r_free_found <= 1'b0;
                        case (i_in.opcode)
                            OP_BEGIN, OP_END: begin
                                r_state <= S_SCAN;
                            end
                            OP_READ: begin
                                r_kind  <= K_READ;
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_kind  <= K_CLEAR;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_slot <= r_chk_idx;
                        if (r_is_end) begin
                            r_kind  <= K_END;
                            r_state <= S_DIFF;
                        end else begin
                            r_kind  <= K_BEGIN_HIT;
                            r_state <= S_FIN;
                        end
                    end else begin
                        if (free_now && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_chk_idx;
                        end
                        if (scan_last) begin
                            r_state <= S_FIN;
                            if (r_is_end) begin
                                r_kind <= K_MISS;
                            end else if (any_free) begin
                                r_kind <= K_ALLOC;
                                r_slot <= first_free;
                            end else begin
                                r_kind <= K_FULL;
                            end
                        end else begin
                            // check follows issue in the next cycle (registered read)
                            r_chk     <= !r_issued_all;
                            r_chk_idx <= r_idx;
                            if (!r_issued_all) begin
                                r_idx        <= r_idx + IW'(1);
                                r_issued_all <= (r_idx == LAST_IDX);
                            end
                        end
                    end
                end
                S_DIFF: begin
                    r_d     <= alu_res.res;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= alu_res.res;
                    r_state <= S_CMIN;
                end
                S_CMIN: begin
                    r_lt    <= alu_res.less;
                    r_state <= S_CMAX;
                end
                S_CMAX: begin
                    r_gt    <= alu_res.less;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out    <= res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_kind == K_ALLOC) begin
                            r_valid[r_slot] <= 1'b1;
                        end
                        if (r_kind == K_CLEAR) begin
                            r_valid <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_out.status;
    assign o_out.slot_index  = r_out.slot_index;
    assign o_out.slot_in_use = r_out.slot_in_use;
    assign o_out.entry_key   = r_out.entry_key;
    assign o_out.total_ticks = r_out.total_ticks;
    assign o_out.call_total  = r_out.call_total;
    assign o_out.min_ticks   = r_out.min_ticks;
    assign o_out.max_ticks   = r_out.max_ticks;

endmodule
`default_nettype wire

// ===== rtl/slpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slpt_checker
    import slpt_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire [1:0]         i_out_status,
    input wire               i_out_in_use,
    input wire [63:0]        i_out_key,
    input wire signed [63:0] i_out_total,
    input wire [31:0]        i_out_calls
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK || i_out_status == ST_NOT_FOUND ||
                         i_out_status == ST_FULL))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |->
            !i_out_in_use && i_out_key == '0 && i_out_calls == '0)
        else $error("error result carries slot data");

    a_free_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_OK && !i_out_in_use |->
            i_out_calls == '0 && i_out_total == '0)
        else $error("free slot reports statistics");

endmodule

bind section_latency_profiler_table slpt_checker u_slpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_in_use (o_out.slot_in_use),
    .i_out_key    (o_out.entry_key),
    .i_out_total  (o_out.total_ticks),
    .i_out_calls  (o_out.call_total)
);
`default_nettype wire

// ===== bench/slpt_stats_checker.sv =====
`timescale 1ns / 1ps
module slpt_stats_checker
    import slpt_pkg::*;
#(
    parameter int SLOTS = 16
)(
    input  wire i_clk,
    input  wire i_rst_n,
    slpt_in_if  i_in_mon,
    slpt_out_if i_out_mon,
    output int  o_mismatch_count,
    output int  o_pending_count,
    output int  o_result_count
);

    // shadow copy of the section table
    bit                       used_q  [SLOTS];
    logic [KEY_W-1:0]         key_q   [SLOTS];
    logic [TS_W-1:0]          start_q [SLOTS];
    logic signed [TICK_W-1:0] sum_q   [SLOTS];
    logic [CNT_W-1:0]         calls_q [SLOTS];
    logic signed [TICK_W-1:0] min_q   [SLOTS];
    logic signed [TICK_W-1:0] max_q   [SLOTS];

    t_result expected_reports[$];

    function automatic void empty_table();
        for (int i = 0; i < SLOTS; i++) begin
            used_q[i]  = 1'b0;
            key_q[i]   = '0;
            start_q[i] = '0;
            sum_q[i]   = '0;
            calls_q[i] = '0;
            min_q[i]   = TICK_MAX;
            max_q[i]   = TICK_MIN;
        end
    endfunction

    // lowest slot in use holding this key, -1 if none
    function automatic int find_section(logic [KEY_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (used_q[i] && key_q[i] == key) hit = i;
        end
        return hit;
    endfunction

    function automatic t_result slot_view(int s);
        t_result r;
        r.status      = ST_OK;
        r.slot_index  = s[RS_W-1:0];
        r.slot_in_use = used_q[s];
        r.entry_key   = key_q[s];
        r.total_ticks = sum_q[s];
        r.call_total  = calls_q[s];
        r.min_ticks   = min_q[s];
        r.max_ticks   = max_q[s];
        return r;
    endfunction

    // applies one transfer to the shadow table and returns the report it should produce
    function automatic t_result predict_slot_report(logic [1:0] op, logic [KEY_W-1:0] key,
                                                    logic [TS_W-1:0] ts, logic [RS_W-1:0] rs);
        t_result                  r;
        int                       s;
        logic signed [TICK_W-1:0] delta;
        r = '0;
        case (op)
            OP_BEGIN: begin
                s = find_section(key);
                for (int i = 0; i < SLOTS && s < 0; i++) begin
                    if (!used_q[i]) begin
                        s = i;
                        used_q[i] = 1'b1;
                        key_q[i]  = key;
                    end
                end
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    start_q[s] = ts;
                    r = slot_view(s);
                end
            end
            OP_END: begin
                s = find_section(key);
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    delta = $signed({1'b0, ts} - {1'b0, start_q[s]});
                    sum_q[s] = sum_q[s] + delta;
                    if (calls_q[s] != CNT_SAT) calls_q[s] = calls_q[s] + 1'b1;
                    if (delta < min_q[s]) min_q[s] = delta;
                    if (max_q[s] < delta) max_q[s] = delta;
                    r = slot_view(s);
                end
            end
            OP_READ: begin
                if (int'(rs) < SLOTS) begin
                    r = slot_view(int'(rs));
                end else begin
                    r.slot_index = rs;
                    r.min_ticks  = TICK_MAX;
                    r.max_ticks  = TICK_MIN;
                end
            end
            default: empty_table();
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    task automatic compare_report(t_result want);
        int n;
        n = o_result_count;
        if (i_out_mon.status !== want.status)
            report_mismatch($sformatf("result %0d status got %0d want %0d",
                                      n, i_out_mon.status, want.status));
        if (i_out_mon.slot_index !== want.slot_index)
            report_mismatch($sformatf("result %0d slot_index got %0d want %0d",
                                      n, i_out_mon.slot_index, want.slot_index));
        if (i_out_mon.slot_in_use !== want.slot_in_use)
            report_mismatch($sformatf("result %0d slot_in_use got %0b want %0b",
                                      n, i_out_mon.slot_in_use, want.slot_in_use));
        if (i_out_mon.entry_key !== want.entry_key)
            report_mismatch($sformatf("result %0d entry_key got %h want %h",
                                      n, i_out_mon.entry_key, want.entry_key));
        if (i_out_mon.total_ticks !== want.total_ticks)
            report_mismatch($sformatf("result %0d total_ticks got %0d want %0d",
                                      n, i_out_mon.total_ticks, want.total_ticks));
        if (i_out_mon.call_total !== want.call_total)
            report_mismatch($sformatf("result %0d call_total got %0d want %0d",
                                      n, i_out_mon.call_total, want.call_total));
        if (i_out_mon.min_ticks !== want.min_ticks)
            report_mismatch($sformatf("result %0d min_ticks got %0d want %0d",
                                      n, i_out_mon.min_ticks, want.min_ticks));
        if (i_out_mon.max_ticks !== want.max_ticks)
            report_mismatch($sformatf("result %0d max_ticks got %0d want %0d",
                                      n, i_out_mon.max_ticks, want.max_ticks));
    endtask

    initial begin
        o_mismatch_count = 0;
        o_result_count   = 0;
        o_pending_count  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            empty_table();
            expected_reports.delete();
        end else begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("output transfer with no result pending");
                end else begin
                    compare_report(expected_reports.pop_front());
                end
                o_result_count++;
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                expected_reports.push_back(predict_slot_report(i_in_mon.opcode,
                    i_in_mon.section_key, i_in_mon.timestamp, i_in_mon.read_slot));
            end
        end
        o_pending_count <= expected_reports.size();
    end

endmodule

// ===== bench/tb_section_latency_profiler_table.sv =====
`timescale 1ns / 1ps
module tb_section_latency_profiler_table;
    import slpt_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int KEY_POOL = 20;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    slpt_in_if  in_ch ();
    slpt_out_if out_ch ();

    int mismatch_count;
    int pending_count;
    int result_count;

    int sent_count = 0;
    int op_tally[4];
    int burst_left = 0;
    bit hold_done = 1'b0;

    section_latency_profiler_table #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    slpt_stats_checker #(
        .SLOTS(TABLE_SLOTS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count),
        .o_result_count  (result_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sender: bursts of transfers separated by random gaps
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [TS_W-1:0] ts, input logic [RS_W-1:0] rs);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.section_key <= key;
        in_ch.timestamp   <= ts;
        in_ch.read_slot   <= rs;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        op_tally[op]++;
        sent_count++;
    endtask

    // receiver: changing stall modes, plus one long hold-off to back up the block
    initial begin : receiver
        int mode;
        int mode_left;
        mode_left = 0;
        mode = 0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool  [KEY_POOL];
        bit               pool_open [KEY_POOL];
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  tick_now;
        logic [RS_W-1:0]  rs;
        logic [1:0]       op;
        int               pick;
        int               idx;

        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_CLEAR;
        in_ch.section_key <= '0;
        in_ch.timestamp   <= '0;
        in_ch.read_slot   <= '0;
        for (int i = 0; i < 4; i++) op_tally[i] = 0;
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i]  = {$urandom, $urandom};
            pool_open[i] = 1'b0;
        end
        tick_now = TS_W'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clear first
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_END, 64'h5555_AAAA_5555_AAAA, 63'd100, '0);   // unknown key
        send_item(OP_BEGIN, '0, '0, '0);
        send_item(OP_END, '0, '1, '0);                              // largest delta
        send_item(OP_END, '0, '1, '0);                              // again, total wraps
        send_item(OP_BEGIN, '0, '1, '0);                            // restart at top
        send_item(OP_END, '0, '0, '0);                              // most negative delta
        send_item(OP_BEGIN, '1, 63'd5, '1);
        send_item(OP_BEGIN, '1, 63'd10, '1);                        // restart same key
        send_item(OP_END, '1, 63'd12, '1);
        for (int i = 2; i < TABLE_SLOTS; i++)
            send_item(OP_BEGIN, 64'h1000 + i, 63'(i), 4'(i));
        send_item(OP_BEGIN, 64'hDEAD_0000_0000_BEEF, 63'd77, '0);   // table full
        send_item(OP_READ, '0, '0, 4'(TABLE_SLOTS - 1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            key  = {$urandom, $urandom};
            rs   = 4'($urandom_range(0, 15));
            tick_now = tick_now + TS_W'($urandom_range(1, 3000));
            ts = ($urandom_range(0, 9) == 0) ? TS_W'({$urandom, $urandom}) : tick_now;
            if (pick < 1) begin
                op = OP_CLEAR;
                for (int i = 0; i < KEY_POOL; i++) pool_open[i] = 1'b0;
            end else if (pick < 16) begin
                op = OP_READ;
            end else if (pick < 22) begin
                op = ($urandom_range(0, 1) != 0) ? OP_END : OP_BEGIN;
            end else begin
                idx = $urandom_range(0, KEY_POOL - 1);
                key = key_pool[idx];
                if (pool_open[idx] && $urandom_range(0, 9) < 7) begin
                    op = OP_END;
                    // sometimes leave it open for a repeated end
                    if ($urandom_range(0, 4) != 0) pool_open[idx] = 1'b0;
                end else begin
                    op = OP_BEGIN;
                    pool_open[idx] = 1'b1;
                end
            end
            send_item(op, key, ts, rs);
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d transfers in: %0d begin, %0d end, %0d read, %0d clear",
                 sent_count, op_tally[OP_BEGIN], op_tally[OP_END], op_tally[OP_READ],
                 op_tally[OP_CLEAR]);
        $display("%0d results compared, %0d mismatches, one %0d-cycle output hold-off",
                 result_count, mismatch_count, HOLD_CYCLES);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results still pending", pending_count);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
